// File: sv/cme_pkg.sv
// Shared types, codes and constants of the cartridge mapper.
package cme_pkg;

  // Size of the serial EEPROM store in bytes (a power of two, 128 or 256).
  localparam int EEPROM_BYTES = 256;
  localparam int EE_AW        = $clog2(EEPROM_BYTES);

  // Configuration register indexes and their reset values.
  localparam logic CFG_VARIANT    = 1'b0;
  localparam logic CFG_BANK_COUNT = 1'b1;
  localparam logic [8:0] BANK_COUNT_RESET = 9'd16;

  // Event kinds carried by an input word.
  typedef enum logic [1:0] {
    MODE_TICK  = 2'd0,
    MODE_WRITE = 2'd1,
    MODE_READ  = 2'd2
  } mode_t;

  // Mapper register indexes above the eight CHR slots.
  localparam logic [3:0] REG_PRG      = 4'd8;
  localparam logic [3:0] REG_MIRROR   = 4'd9;
  localparam logic [3:0] REG_IRQ_CTRL = 4'd10;
  localparam logic [3:0] REG_IRQ_LO   = 4'd11;
  localparam logic [3:0] REG_IRQ_HI   = 4'd12;
  localparam logic [3:0] REG_EEPROM   = 4'd13;

  // Kind of mapping change reported with a result word.
  typedef enum logic [1:0] {
    UPD_NONE   = 2'd0,
    UPD_CHR    = 2'd1,
    UPD_PRG    = 2'd2,
    UPD_MIRROR = 2'd3
  } upd_t;

  // EEPROM pin positions: clock and data in the byte written to the EEPROM register, ack in the data port read.
  localparam int CLK_BIT = 5;
  localparam int DAT_BIT = 6;
  localparam int ACK_BIT = 4;

  // Serial EEPROM protocol phase.
  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_CMD  = 4'b0010,
    PH_ADDR = 4'b0100,
    PH_DATA = 4'b1000
  } phase_t;

  // Configuration as seen by the datapath.
  typedef struct packed {
    logic       variant;
    logic [8:0] bank_count;
  } cfg_t;

  // Request from the event stage to the EEPROM controller.
  typedef struct packed {
    logic       pin_we;
    logic       rd_en;
    logic [7:0] data;
    logic [7:0] bus;
  } eep_req_t;

endpackage

// File: sv/cme_in_if.sv
// Input channel: one CPU event per word.
interface cme_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [3:0] reg_index;
  logic [7:0] write_data;
  logic [7:0] open_bus;

  modport source (output valid, mode, reg_index, write_data, open_bus, input ready);
  modport sink   (input valid, mode, reg_index, write_data, open_bus, output ready);
endinterface

// File: sv/cme_out_if.sv
// Output channel: one result word per event.
interface cme_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       irq_line;
  logic [1:0] map_update;
  logic [2:0] map_slot;
  logic [7:0] map_bank;

  modport source (output valid, read_data, irq_line, map_update, map_slot, map_bank,
                  input ready);
  modport sink   (input valid, read_data, irq_line, map_update, map_slot, map_bank,
                  output ready);
endinterface

// File: sv/cme_cfg.sv
// APB configuration registers of the mapper.
module cme_cfg (
  input  logic         clk,
  input  logic         rst,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready,
  output cme_pkg::cfg_t cfg,
  output cme_pkg::cfg_t cfg_next
);

  logic wr;
  logic sel;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign sel    = paddr[2];

  // Next register values, also used to prefetch the EEPROM store.
  always_comb begin
    cfg_next = cfg;
    if (wr) begin
      if (sel == cme_pkg::CFG_VARIANT) begin
        cfg_next.variant = pwdata[0];
      end else begin
        cfg_next.bank_count = pwdata[8:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.variant    <= 1'b0;
      cfg.bank_count <= cme_pkg::BANK_COUNT_RESET;
    end else begin
      cfg <= cfg_next;
    end
  end

  // Read back.
  assign prdata = (sel == cme_pkg::CFG_VARIANT) ? {31'd0, cfg.variant}
                                                : {23'd0, cfg.bank_count};

endmodule

// File: sv/cme_eeprom.sv
// Bit-banged serial EEPROM: protocol state and the byte store.
module cme_eeprom (
  input  logic              clk,
  input  logic              rst,
  input  logic              go,
  input  cme_pkg::eep_req_t req,
  input  cme_pkg::cfg_t     cfg,
  input  cme_pkg::cfg_t     cfg_next,
  output logic [7:0]        rd_data
);

  cme_pkg::phase_t phase, phase_next;
  logic [7:0] bit_count, bit_count_next;
  logic [7:0] command, command_next;
  logic [7:0] address, address_next;
  logic [7:0] shift, shift_next;
  logic       prev_clk, prev_dat;
  logic       prev_clk_next, prev_dat_next;

  logic [7:0] mem [cme_pkg::EEPROM_BYTES];
  logic       written [cme_pkg::EEPROM_BYTES];
  logic [7:0] mem_q;
  logic       pf_valid;
  logic       byp_hit;
  logic [7:0] byp_data;
  logic [7:0] store_byte;

  logic                      wr_en;
  logic [cme_pkg::EE_AW-1:0] wr_idx;
  logic [cme_pkg::EE_AW-1:0] pf_idx;

  // Store index: the variant board addresses in halves.
  function automatic logic [cme_pkg::EE_AW-1:0] store_idx(input logic var_b,
                                                         input logic [7:0] a);
    logic [7:0] s;
    s = var_b ? {1'b0, a[7:1]} : a;
    return s[cme_pkg::EE_AW-1:0];
  endfunction

  // The byte at the current index, prefetched in the cycle before.
  assign store_byte = byp_hit ? byp_data : (pf_valid ? mem_q : 8'd0);

  // Protocol step for a pin write or a data port read.
  always_comb begin
    logic       d_clk;
    logic       d_dat;
    logic       rw;
    logic [7:0] bc_inc;
    logic [7:0] b;
    phase_next     = phase;
    bit_count_next = bit_count;
    command_next   = command;
    address_next   = address;
    shift_next     = shift;
    prev_clk_next  = prev_clk;
    prev_dat_next  = prev_dat;
    wr_en          = 1'b0;
    wr_idx         = store_idx(cfg.variant, address);
    rd_data        = 8'd0;
    d_clk          = req.data[cme_pkg::CLK_BIT];
    d_dat          = req.data[cme_pkg::DAT_BIT];
    rw             = cfg.variant ? address[0] : command[0];
    bc_inc         = 8'(bit_count + 8'd1);
    b              = 8'd0;

    if (req.pin_we) begin
      // Start and stop conditions: data moves while the clock stays high.
      if (prev_clk && d_clk) begin
        if (prev_dat && !d_dat) begin
          phase_next     = cfg.variant ? cme_pkg::PH_ADDR : cme_pkg::PH_CMD;
          bit_count_next = 8'd0;
        end else if (!prev_dat && d_dat) begin
          phase_next = cme_pkg::PH_IDLE;
        end
      end
      // Rising clock edge shifts one bit.
      if (!prev_clk && d_clk) begin
        unique case (phase)
          cme_pkg::PH_CMD: begin
            if (bit_count < 8'd8) command_next = {command[6:0], d_dat};
            bit_count_next = bc_inc;
          end
          cme_pkg::PH_ADDR: begin
            if (bit_count < 8'd8) address_next = {address[6:0], d_dat};
            bit_count_next = bc_inc;
          end
          cme_pkg::PH_DATA: begin
            if (!rw) begin
              shift_next     = {shift[6:0], d_dat};
              bit_count_next = bc_inc;
              if (bc_inc == 8'd8) begin
                wr_en        = 1'b1;
                address_next = 8'(address + (cfg.variant ? 8'd2 : 8'd1));
              end
            end else if (bit_count == 8'd8) begin
              bit_count_next = bc_inc;
              address_next   = 8'(address + (cfg.variant ? 8'd2 : 8'd1));
            end
          end
          cme_pkg::PH_IDLE: begin
          end
          default: begin
          end
        endcase
      end
      prev_clk_next = d_clk;
      prev_dat_next = d_dat;
    end else if (req.rd_en) begin
      // Data port read: ack after the ninth bit, or the next data bit.
      rd_data = req.bus;
      unique case (phase)
        cme_pkg::PH_CMD: begin
          if (bit_count == 8'd9) begin
            bit_count_next = 8'd0;
            phase_next     = command[0] ? cme_pkg::PH_DATA : cme_pkg::PH_ADDR;
            rd_data        = 8'd0;
          end
        end
        cme_pkg::PH_ADDR: begin
          if (bit_count == 8'd9) begin
            bit_count_next = 8'd0;
            phase_next     = cme_pkg::PH_DATA;
            rd_data        = 8'd0;
          end
        end
        cme_pkg::PH_DATA: begin
          b       = (bit_count == 8'd9) ? 8'd0 : bit_count;
          rd_data = 8'd0;
          if (b < 8'd8) rd_data[cme_pkg::ACK_BIT] = store_byte[b[2:0]];
          bit_count_next = 8'(b + 8'd1);
        end
        cme_pkg::PH_IDLE: begin
        end
        default: begin
        end
      endcase
    end
  end

  // Protocol registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= cme_pkg::PH_IDLE;
      bit_count <= 8'd0;
      command   <= 8'd0;
      address   <= 8'd0;
      shift     <= 8'd0;
      prev_clk  <= 1'b0;
      prev_dat  <= 1'b0;
    end else if (go) begin
      phase     <= phase_next;
      bit_count <= bit_count_next;
      command   <= command_next;
      address   <= address_next;
      shift     <= shift_next;
      prev_clk  <= prev_clk_next;
      prev_dat  <= prev_dat_next;
    end
  end

  // Index that the next word will read.
  assign pf_idx = go ? store_idx(cfg_next.variant, address_next)
                     : store_idx(cfg_next.variant, address);

  // Store array, written on the eighth bit and prefetched into a register.
  always_ff @(posedge clk) begin
    if (go && wr_en) mem[wr_idx] <= shift_next;
    mem_q    <= mem[pf_idx];
    byp_data <= shift_next;
  end

  // Written flags make unwritten bytes read as zero after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < cme_pkg::EEPROM_BYTES; i++) written[i] <= 1'b0;
      pf_valid <= 1'b0;
      byp_hit  <= 1'b0;
    end else begin
      if (go && wr_en) written[wr_idx] <= 1'b1;
      pf_valid <= written[pf_idx];
      byp_hit  <= go && wr_en && (wr_idx == pf_idx);
    end
  end

  // A byte is stored only in the data phase.
  a_wr_in_data: assert property (@(posedge clk) disable iff (rst)
    go && wr_en |-> phase == cme_pkg::PH_DATA)
    else $error("EEPROM store written outside the data phase");

  // A store write moves the address on.
  a_wr_step: assert property (@(posedge clk) disable iff (rst)
    go && wr_en |=> address != $past(address))
    else $error("EEPROM address did not advance after a store write");

  // An address ack moves on to the data phase with the count cleared.
  a_ack_reset: assert property (@(posedge clk) disable iff (rst)
    go && req.rd_en && (phase == cme_pkg::PH_ADDR) && bit_count == 8'd9
    |=> phase == cme_pkg::PH_DATA && bit_count == 8'd0)
    else $error("address ack did not enter the data phase");

endmodule

// File: sv/cartridge_mapper_irq_eeprom.sv
// Top level: event stage, banking and IRQ counter, result register.
// Flow: a word accepted into the input stage is decoded there, and its result is
// written to the output register when the stage advances.
// Throughput: one word per cycle while the receiver takes results; the single pass from input to result
// register and the registered EEPROM prefetch set this figure.
// Reset (rst, synchronous): clears the IRQ, EEPROM protocol state and store
// flags at once, so the store reads as zero; no clearing pass is needed.
module cartridge_mapper_irq_eeprom (
  input  logic        clk,
  input  logic        rst,
  cme_in_if.sink      in_ch,
  cme_out_if.source   out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cme_pkg::cfg_t    cfg, cfg_next;
  cme_pkg::eep_req_t eep_req;
  logic [7:0]       eep_rd;

  // Input stage.
  logic       s1_valid;
  logic [1:0] s1_mode;
  logic [3:0] s1_reg;
  logic [7:0] s1_data;
  logic [7:0] s1_bus;
  logic       advance;

  // IRQ state.
  logic [15:0] irq_count, irq_count_next;
  logic        irq_enable, irq_enable_next;
  logic        irq_pending, irq_pending_next;

  // Result of the word in the input stage.
  logic [7:0]  res_read;
  logic [1:0]  res_upd;
  logic [2:0]  res_slot;
  logic [7:0]  res_bank;

  cme_cfg u_cfg (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cfg, .cfg_next
  );

  // The stage advances when the result register is free or being emptied.
  assign advance     = s1_valid && (!out_ch.valid || out_ch.ready);
  assign in_ch.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_mode <= in_ch.mode;
      s1_reg  <= in_ch.reg_index;
      s1_data <= in_ch.write_data;
      s1_bus  <= in_ch.open_bus;
    end
  end

  // EEPROM requests from register 13 writes and data port reads.
  always_comb begin
    eep_req.pin_we = (s1_mode == cme_pkg::MODE_WRITE) && (s1_reg == cme_pkg::REG_EEPROM);
    eep_req.rd_en  = (s1_mode == cme_pkg::MODE_READ);
    eep_req.data   = s1_data;
    eep_req.bus    = s1_bus;
  end

  cme_eeprom u_eeprom (
    .clk, .rst, .go(advance), .req(eep_req), .cfg, .cfg_next, .rd_data(eep_rd)
  );

  // Banking, mirroring and IRQ counter.
  always_comb begin
    logic [8:0] mask;
    logic [8:0] prg;
    mask             = 9'(cfg.bank_count - 9'd1);
    prg              = {s1_data, 1'b0} & mask;
    irq_count_next   = irq_count;
    irq_enable_next  = irq_enable;
    irq_pending_next = irq_pending;
    res_read         = 8'd0;
    res_upd          = cme_pkg::UPD_NONE;
    res_slot         = 3'd0;
    res_bank         = 8'd0;
    unique case (s1_mode)
      cme_pkg::MODE_TICK: begin
        if (irq_enable) begin
          irq_count_next = 16'(irq_count - 16'd1);
          if (irq_count_next == 16'd0) irq_pending_next = 1'b1;
        end
      end
      cme_pkg::MODE_WRITE: begin
        if (!s1_reg[3]) begin
          res_upd  = cme_pkg::UPD_CHR;
          res_slot = s1_reg[2:0];
          res_bank = s1_data;
        end else begin
          unique case (s1_reg)
            cme_pkg::REG_PRG: begin
              res_upd  = cme_pkg::UPD_PRG;
              res_bank = prg[7:0];
            end
            cme_pkg::REG_MIRROR: begin
              res_upd  = cme_pkg::UPD_MIRROR;
              res_bank = {6'd0, s1_data[1:0]};
            end
            cme_pkg::REG_IRQ_CTRL: begin
              irq_enable_next  = s1_data[0];
              irq_pending_next = 1'b0;
            end
            cme_pkg::REG_IRQ_LO: irq_count_next = {irq_count[15:8], s1_data};
            cme_pkg::REG_IRQ_HI: irq_count_next = {s1_data, irq_count[7:0]};
            default: begin
            end
          endcase
        end
      end
      cme_pkg::MODE_READ: res_read = eep_rd;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      irq_count   <= 16'd0;
      irq_enable  <= 1'b0;
      irq_pending <= 1'b0;
    end else if (advance) begin
      irq_count   <= irq_count_next;
      irq_enable  <= irq_enable_next;
      irq_pending <= irq_pending_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (advance) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_ch.read_data  <= res_read;
      out_ch.irq_line   <= irq_pending_next;
      out_ch.map_update <= res_upd;
      out_ch.map_slot   <= res_slot;
      out_ch.map_bank   <= res_bank;
    end
  end

  // A tick that takes the counter from one to zero raises the IRQ.
  a_irq_raise: assert property (@(posedge clk) disable iff (rst)
    advance && s1_mode == cme_pkg::MODE_TICK && irq_enable && irq_count == 16'd1
    |=> irq_pending)
    else $error("IRQ not raised when the counter reached zero");

  // Writing the IRQ control register acknowledges the IRQ.
  a_irq_ack: assert property (@(posedge clk) disable iff (rst)
    advance && s1_mode == cme_pkg::MODE_WRITE && s1_reg == cme_pkg::REG_IRQ_CTRL
    |=> !irq_pending)
    else $error("IRQ still pending after a control write");

  // The input side stalls only with both stages full.
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    !in_ch.ready |-> s1_valid && out_ch.valid && !out_ch.ready)
    else $error("input stalled with room in the pipeline");

  // A decoded word always lands in the result register.
  a_result: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_ch.valid)
    else $error("result lost after decode");

endmodule

// File: bench/tb_top.sv
// Self-checking testbench for the cartridge mapper: predicts and checks every result word.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // Codes that the package leaves unnamed.
  localparam logic [1:0] MODE_SPARE  = 2'd3;
  localparam logic [3:0] REG_SPARE_A = 4'd14;
  localparam logic [3:0] REG_SPARE_B = 4'd15;
  localparam int         CHR_SLOTS   = 8;

  localparam int IDLE_LIMIT  = 4000;
  localparam int HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES = 8;

  typedef struct packed {
    logic [7:0]    read_data;
    logic          irq_line;
    cme_pkg::upd_t map_update;
    logic [2:0]    map_slot;
    logic [7:0]    map_bank;
  } mapper_word_t;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  cme_in_if  in_ch ();
  cme_out_if out_ch ();

  cartridge_mapper_irq_eeprom dut (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Mirror of the mapper state used to predict each result word.
  logic            cfg_variant;
  logic [8:0]      cfg_bank_count;
  logic [7:0]      pins_prev;
  logic [15:0]     irq_count;
  logic            irq_enabled;
  logic            irq_raised;
  cme_pkg::phase_t ee_phase;
  logic [7:0]      ee_bits;
  logic [7:0]      ee_cmd;
  logic [7:0]      ee_addr;
  logic [7:0]      ee_shift;
  logic [7:0]      ee_store [cme_pkg::EEPROM_BYTES];

  mapper_word_t pending_results [$];
  int           fail_count  = 0;
  int           items_sent  = 0;
  int           hold_asked  = 0;
  int           hold_served = 0;
  bit           feed_gaps   = 1'b1;
  bit           sink_gaps   = 1'b1;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Store index: the second board variant addresses in pairs of bytes.
  function automatic int ee_index();
    logic [7:0] a;
    a = cfg_variant ? (ee_addr >> 1) : ee_addr;
    return int'(a) % cme_pkg::EEPROM_BYTES;
  endfunction

  function automatic void ee_advance();
    ee_addr = ee_addr + (cfg_variant ? 8'd2 : 8'd1);
  endfunction

  // Clock and data pins written through the EEPROM register.
  function automatic void ee_pins(logic [7:0] d);
    logic din;
    logic rw;
    din = d[cme_pkg::DAT_BIT];
    // Data edges while the clock stays high mark start and stop.
    if (pins_prev[cme_pkg::CLK_BIT] && d[cme_pkg::CLK_BIT]) begin
      if (pins_prev[cme_pkg::DAT_BIT] && !d[cme_pkg::DAT_BIT]) begin
        if (cfg_variant) ee_phase = cme_pkg::PH_ADDR;
        else ee_phase = cme_pkg::PH_CMD;
        ee_bits = 8'd0;
      end
      if (!pins_prev[cme_pkg::DAT_BIT] && d[cme_pkg::DAT_BIT]) ee_phase = cme_pkg::PH_IDLE;
    end
    // A rising clock shifts one bit in the current phase.
    if (!pins_prev[cme_pkg::CLK_BIT] && d[cme_pkg::CLK_BIT]) begin
      case (ee_phase)
        cme_pkg::PH_CMD: begin
          if (ee_bits < 8) ee_cmd = {ee_cmd[6:0], din};
          ee_bits++;
        end
        cme_pkg::PH_ADDR: begin
          if (ee_bits < 8) ee_addr = {ee_addr[6:0], din};
          ee_bits++;
        end
        cme_pkg::PH_DATA: begin
          rw = cfg_variant ? ee_addr[0] : ee_cmd[0];
          if (!rw) begin
            ee_shift = {ee_shift[6:0], din};
            ee_bits++;
            if (ee_bits == 8) begin
              ee_store[ee_index()] = ee_shift;
              ee_advance();
            end
          end else if (ee_bits == 8) begin
            ee_bits++;
            ee_advance();
          end
        end
        default: ;
      endcase
    end
    pins_prev = d;
  endfunction

  // Read of the data port: ack, a stored bit, or the open bus byte.
  function automatic logic [7:0] ee_port(logic [7:0] bus);
    logic [7:0] r;
    logic [7:0] v;
    r = bus;
    case (ee_phase)
      cme_pkg::PH_CMD: begin
        if (ee_bits == 9) begin
          ee_bits = 8'd0;
          if (ee_cmd[0]) ee_phase = cme_pkg::PH_DATA;
          else ee_phase = cme_pkg::PH_ADDR;
          r = 8'h00;
        end
      end
      cme_pkg::PH_ADDR: begin
        if (ee_bits == 9) begin
          ee_bits  = 8'd0;
          ee_phase = cme_pkg::PH_DATA;
          r        = 8'h00;
        end
      end
      cme_pkg::PH_DATA: begin
        if (ee_bits == 9) ee_bits = 8'd0;
        v = ee_store[ee_index()];
        if (ee_bits < 8) r = 8'(v[ee_bits[2:0]]) << cme_pkg::ACK_BIT;
        else r = 8'h00;
        ee_bits++;
      end
      default: ;
    endcase
    return r;
  endfunction

  // Expected result word of one accepted event.
  function automatic mapper_word_t predict_event(logic [1:0] m, logic [3:0] r,
                                                 logic [7:0] d, logic [7:0] bus);
    mapper_word_t res;
    logic [8:0]   mask;
    logic [8:0]   bank9;
    res = '0;
    case (m)
      cme_pkg::MODE_TICK: begin
        if (irq_enabled) begin
          irq_count--;
          if (irq_count == 16'h0000) irq_raised = 1'b1;
        end
      end
      cme_pkg::MODE_WRITE: begin
        if (r < CHR_SLOTS) begin
          res.map_update = cme_pkg::UPD_CHR;
          res.map_slot   = r[2:0];
          res.map_bank   = d;
        end else begin
          case (r)
            cme_pkg::REG_PRG: begin
              mask           = cfg_bank_count - 9'd1;
              bank9          = {d, 1'b0} & mask;
              res.map_update = cme_pkg::UPD_PRG;
              res.map_bank   = bank9[7:0];
            end
            cme_pkg::REG_MIRROR: begin
              res.map_update = cme_pkg::UPD_MIRROR;
              res.map_bank   = {6'd0, d[1:0]};
            end
            cme_pkg::REG_IRQ_CTRL: begin
              irq_enabled = d[0];
              irq_raised  = 1'b0;
            end
            cme_pkg::REG_IRQ_LO: irq_count[7:0]  = d;
            cme_pkg::REG_IRQ_HI: irq_count[15:8] = d;
            cme_pkg::REG_EEPROM: ee_pins(d);
            default: ;
          endcase
        end
      end
      cme_pkg::MODE_READ: res.read_data = ee_port(bus);
      default: ;
    endcase
    res.irq_line = irq_raised;
    return res;
  endfunction

  function automatic void model_reset();
    cfg_variant    = 1'b0;
    cfg_bank_count = cme_pkg::BANK_COUNT_RESET;
    pins_prev      = 8'h00;
    irq_count      = 16'h0000;
    irq_enabled    = 1'b0;
    irq_raised     = 1'b0;
    ee_phase       = cme_pkg::PH_IDLE;
    ee_bits        = 8'h00;
    ee_cmd         = 8'h00;
    ee_addr        = 8'h00;
    ee_shift       = 8'h00;
    foreach (ee_store[i]) ee_store[i] = 8'h00;
  endfunction

  // Send one word, with random gaps before it; valid stays high afterwards.
  task automatic send_word(logic [1:0] m, logic [3:0] r, logic [7:0] d, logic [7:0] bus);
    while (feed_gaps && $urandom_range(0, 99) < 19) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.mode       <= m;
    in_ch.reg_index  <= r;
    in_ch.write_data <= d;
    in_ch.open_bus   <= bus;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending_results.push_back(predict_event(m, r, d, bus));
    if (m != MODE_SPARE && !(m == cme_pkg::MODE_WRITE && r >= REG_SPARE_A)) items_sent++;
  endtask

  task automatic tick();
    send_word(cme_pkg::MODE_TICK, 4'($urandom), 8'($urandom), 8'($urandom));
  endtask

  task automatic port_read();
    send_word(cme_pkg::MODE_READ, 4'($urandom), 8'($urandom), 8'($urandom));
  endtask

  task automatic reg_write(logic [3:0] r, logic [7:0] d);
    send_word(cme_pkg::MODE_WRITE, r, d, 8'($urandom));
  endtask

  // EEPROM pins, with random content in the bits that carry no pin.
  task automatic pin(logic c, logic dt);
    logic [7:0] d;
    d                   = 8'($urandom);
    d[cme_pkg::CLK_BIT] = c;
    d[cme_pkg::DAT_BIT] = dt;
    reg_write(cme_pkg::REG_EEPROM, d);
  endtask

  task automatic ee_clock(logic b);
    pin(1'b0, b);
    pin(1'b1, b);
  endtask

  task automatic ee_start();
    pin(1'b0, 1'b1);
    pin(1'b1, 1'b1);
    pin(1'b1, 1'b0);
  endtask

  task automatic ee_stop();
    pin(1'b0, 1'b0);
    pin(1'b1, 1'b0);
    pin(1'b1, 1'b1);
  endtask

  task automatic ee_byte(logic [7:0] v);
    for (int i = 7; i >= 0; i--) ee_clock(v[i]);
  endtask

  // Acknowledge clock, then the read that collects the ack.
  task automatic ee_ack();
    ee_clock(1'($urandom));
    port_read();
  endtask

  // Lower valid and wait until every expected word has come back.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Configuration write: setup cycle, then access cycle.
  task automatic apb_write(logic idx, logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (idx == cme_pkg::CFG_VARIANT) cfg_variant = data[0];
    else cfg_bank_count = data[8:0];
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Load the counter with a small value (now and then a large one), enable it most of the time and tick towards zero.
  task automatic irq_burst();
    int n;
    n = $urandom_range(1, 12);
    reg_write(cme_pkg::REG_IRQ_LO, 8'(n));
    reg_write(cme_pkg::REG_IRQ_HI, ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'h00);
    reg_write(cme_pkg::REG_IRQ_CTRL, {7'($urandom), 1'($urandom_range(0, 5) != 0)});
    repeat (n + $urandom_range(0, 3)) tick();
    if ($urandom_range(0, 1)) reg_write(cme_pkg::REG_IRQ_CTRL, 8'($urandom));
  endtask

  // One well-formed EEPROM transaction with random content; now and then it
  // reads short of or past the byte, skips the final stop or stays in the data phase.
  task automatic ee_transaction();
    logic       rw;
    logic [7:0] where;
    int         nbytes;
    int         nreads;
    rw     = 1'($urandom);
    where  = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 7));
    nbytes = $urandom_range(1, 3);
    ee_start();
    if (cfg_variant) begin
      ee_byte({where[7:1], rw});
      ee_ack();
    end else begin
      if (rw && $urandom_range(0, 1)) begin
        // Dummy write to set the address, then a repeated start for reading.
        ee_byte({7'($urandom), 1'b0});
        ee_ack();
        ee_byte(where);
        ee_ack();
        ee_start();
      end
      ee_byte({7'($urandom), rw});
      ee_ack();
      if (!rw) begin
        ee_byte(where);
        ee_ack();
      end
    end
    for (int k = 0; k < nbytes; k++) begin
      if (rw) begin
        nreads = ($urandom_range(0, 4) == 0) ? $urandom_range(7, 10) : 8;
        repeat (nreads) port_read();
        ee_clock(1'b1);
      end else begin
        ee_byte(8'($urandom));
        ee_clock(1'($urandom));
        if ($urandom_range(0, 1)) port_read();
      end
    end
    if ($urandom_range(0, 6) != 0) ee_stop();
  endtask

  // A single event of any kind, ignored ones among them.
  task automatic random_event();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 30) tick();
    else if (pick < 60) reg_write(4'($urandom_range(0, 12)), 8'($urandom));
    else if (pick < 75) port_read();
    else if (pick < 85) pin(1'($urandom), 1'($urandom));
    else if (pick < 90) reg_write($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, 8'($urandom));
    else if (pick < 95) send_word(MODE_SPARE, 4'($urandom), 8'($urandom), 8'($urandom));
    else reg_write(cme_pkg::REG_PRG, 8'($urandom));
  endtask

  // CHR slots, PRG pair, mirroring, unused registers, the spare mode and port reads.
  task automatic test_banking();
    reg_write(4'd0, 8'h00);
    reg_write(4'd7, 8'hFF);
    reg_write(4'd3, 8'hA5);
    reg_write(cme_pkg::REG_PRG, 8'hFF);
    reg_write(cme_pkg::REG_PRG, 8'h00);
    reg_write(cme_pkg::REG_MIRROR, 8'hFF);
    reg_write(cme_pkg::REG_MIRROR, 8'h02);
    reg_write(REG_SPARE_A, 8'hFF);
    reg_write(REG_SPARE_B, 8'h55);
    send_word(MODE_SPARE, 4'hF, 8'hFF, 8'hFF);
    send_word(cme_pkg::MODE_READ, 4'h0, 8'h00, 8'hFF);
    send_word(cme_pkg::MODE_READ, 4'hF, 8'hFF, 8'h00);
  endtask

  // Counter reaching zero, wrapping past zero, acknowledge and disable.
  task automatic test_irq_counter();
    reg_write(cme_pkg::REG_IRQ_LO, 8'h02);
    reg_write(cme_pkg::REG_IRQ_HI, 8'h00);
    reg_write(cme_pkg::REG_IRQ_CTRL, 8'h01);
    tick();
    tick();
    tick();
    reg_write(cme_pkg::REG_IRQ_CTRL, 8'hFE);
    tick();
    reg_write(cme_pkg::REG_IRQ_HI, 8'hFF);
  endtask

  // The sender stops until every word has come back, then carries on.
  task automatic test_sender_pause();
    irq_burst();
    wait_drained();
    repeat (6) random_event();
  endtask

  // The receiver holds off for a long stretch while words keep coming.
  task automatic test_backpressure();
    hold_asked++;
    repeat (40) random_event();
  endtask

  // Random traffic under a series of configurations, extremes included.
  task automatic test_random_traffic();
    logic       variants [7] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
    logic [8:0] counts   [7] = '{9'd256, 9'd2, 9'd0, 9'd1, 9'd511, 9'd48, 9'd16};
    int         phase_end;
    int         pick;
    for (int p = 0; p < 7; p++) begin
      wait_drained();
      apb_write(cme_pkg::CFG_VARIANT, {31'($urandom), variants[p]});
      apb_write(cme_pkg::CFG_BANK_COUNT, {23'($urandom), counts[p]});
      // One stretch runs with no gaps on either side.
      feed_gaps = (p != 3);
      sink_gaps = (p != 3);
      phase_end = items_sent + 40;
      while (items_sent < phase_end) begin
        pick = $urandom_range(0, 99);
        if (pick < 40) ee_transaction();
        else if (pick < 55) irq_burst();
        else random_event();
      end
    end
    feed_gaps = 1'b1;
    sink_gaps = 1'b1;
  endtask

  // Stimulus and the end of the run.
  initial begin : stimulus
    in_ch.valid      <= 1'b0;
    in_ch.mode       <= cme_pkg::MODE_TICK;
    in_ch.reg_index  <= 4'd0;
    in_ch.write_data <= 8'h00;
    in_ch.open_bus   <= 8'h00;
    psel             <= 1'b0;
    penable          <= 1'b0;
    pwrite           <= 1'b0;
    paddr            <= 3'd0;
    pwdata           <= 32'd0;
    rst              <= 1'b1;
    model_reset();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_banking();
    test_irq_counter();
    test_sender_pause();
    test_backpressure();
    test_random_traffic();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

  // Receiver: random stalls, and a long hold-off when one is asked for.
  initial begin : sink_side
    int held;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_asked != hold_served) begin
        hold_served = hold_asked;
        out_ch.ready <= 1'b0;
        held = 0;
        while (held < HOLD_CYCLES) begin
          @(posedge clk);
          held++;
        end
      end else begin
        out_ch.ready <= !sink_gaps || ($urandom_range(0, 99) >= 19);
      end
    end
  end

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endfunction

  // Each result word is compared with the oldest expectation.
  always @(posedge clk) begin : result_check
    mapper_word_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("result word arrived with nothing expected");
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("read_data", 16'(want.read_data), 16'(out_ch.read_data));
        check_field("irq_line", 16'(want.irq_line), 16'(out_ch.irq_line));
        check_field("map_update", 16'(want.map_update), 16'(out_ch.map_update));
        check_field("map_slot", 16'(want.map_slot), 16'(out_ch.map_slot));
        check_field("map_bank", 16'(want.map_bank), 16'(out_ch.map_bank));
      end
    end
  end

  // Watchdog: too long without any word moving on either side ends the run.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("tb_top: done, errors");
    $finish;
  end

endmodule
